@@ rtl/core/lsbi_pkg.sv @@
// ----------------------------------------------------------------------------
// LSB-I extractor package
// Shared item types, event type and outcome codes.
// ----------------------------------------------------------------------------
package lsbi_pkg;

    localparam logic [1:0] OUTCOME_MORE    = 2'd0;
    localparam logic [1:0] OUTCOME_SUCCESS = 2'd1;
    localparam logic [1:0] OUTCOME_FAIL    = 2'd2;

    localparam logic [2:0] HEADER_BYTES  = 3'd4;
    localparam logic [33:0] OK_OFFSET    = 34'd4;
    localparam logic [33:0] FAIL_OFFSET  = 34'd68;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       first_of_image;
        logic       last_of_image;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [1:0]  outcome;
        logic [33:0] message_length;
    } out_item_t;

    typedef struct packed {
        logic first;
        logic last;
        logic bit_vld;
        logic bit_val;
    } bit_event_t;

endpackage

@@ rtl/core/lsbi_front.sv @@
// ----------------------------------------------------------------------------
// LSB-I front end
// Accepts pixel bytes, tracks the control word and turns each byte into a
// bit event for the back end.
// ----------------------------------------------------------------------------
module lsbi_front import lsbi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    input  logic [3:0]  control_word,
    input  logic        q_full,
    output logic        push,
    output bit_event_t  push_event
);

    logic [2:0] pos_reg, pos_next;
    logic [1:0] mod3_reg, mod3_next;
    logic [3:0] ctrl_reg, ctrl_next;
    logic       xv_reg, xv_next;
    logic [2:0] pos_c;
    logic [1:0] mod3_c;
    logic [3:0] ctrl_c;
    logic       xv_c;
    logic [1:0] pattern;
    logic [7:0] b;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;
    assign b        = in_item.pixel_byte;
    assign pattern  = b[2:1];

    always_comb
    begin
        pos_c  = pos_reg;
        mod3_c = mod3_reg;
        ctrl_c = ctrl_reg;
        xv_c   = xv_reg;
        if (in_item.first_of_image)
        begin
            pos_c  = 3'd0;
            mod3_c = 2'd0;
            ctrl_c = 4'd0;
            xv_c   = 1'b0;
        end
        ctrl_next = ctrl_c;
        xv_next   = xv_c;
        push_event.first   = in_item.first_of_image;
        push_event.last    = in_item.last_of_image;
        push_event.bit_vld = 1'b0;
        push_event.bit_val = 1'b0;
        if (pos_c < HEADER_BYTES)
        begin
            ctrl_next = {ctrl_c[2:0], b[0]};
            if (pos_c == HEADER_BYTES - 3'd1)
            begin
                xv_next = (ctrl_next == control_word);
            end
        end
        else if (xv_c || mod3_c != 2'd2)
        begin
            push_event.bit_vld = 1'b1;
            if (xv_c)
            begin
                push_event.bit_val = b[0] ^ b[7];
            end
            else
            begin
                push_event.bit_val = b[0] ^ ctrl_c[2'd3 - pattern];
            end
        end
        pos_next  = (pos_c == HEADER_BYTES) ? pos_c : pos_c + 3'd1;
        mod3_next = (mod3_c == 2'd2) ? 2'd0 : mod3_c + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 3'd0;
            mod3_reg <= 2'd0;
            ctrl_reg <= 4'd0;
            xv_reg   <= 1'b0;
        end
        else if (push)
        begin
            pos_reg  <= pos_next;
            mod3_reg <= mod3_next;
            ctrl_reg <= ctrl_next;
            xv_reg   <= xv_next;
        end
    end

endmodule

@@ rtl/core/lsbi_queue.sv @@
// ----------------------------------------------------------------------------
// LSB-I event queue
// Two-entry queue of bit events between the front and back ends.
// ----------------------------------------------------------------------------
module lsbi_queue import lsbi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  bit_event_t push_event,
    output logic       full,
    output logic       head_vld,
    input  logic       pop,
    output bit_event_t head
);

    bit_event_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign head_vld = (count_reg != 2'd0);
    assign head     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_event;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/core/lsbi_back.sv @@
// ----------------------------------------------------------------------------
// LSB-I back end
// Packs bits into bytes, parses the length header, detects the terminator
// and failures, and holds the result in an output register.
// ----------------------------------------------------------------------------
module lsbi_back import lsbi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_vld,
    input  bit_event_t head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_item
);

    logic [7:0]  acc_reg, acc_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] len_reg, len_next;
    logic [33:0] emit_reg, emit_next;
    logic [33:0] thr_ok_reg, thr_ok_next;
    logic [33:0] thr_fail_reg, thr_fail_next;
    logic        done_reg, done_next;
    logic        out_vld_reg;
    out_item_t   out_item_reg;
    logic        res_vld;
    out_item_t   res;
    logic        produced;
    logic [7:0]  value;
    logic [33:0] idx;

    assign pop       = head_vld && (!out_vld_reg || !out_stall);
    assign out_valid = out_vld_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        len_next      = len_reg;
        emit_next     = emit_reg;
        thr_ok_next   = thr_ok_reg;
        thr_fail_next = thr_fail_reg;
        done_next     = done_reg;
        res_vld       = 1'b0;
        res           = '0;
        produced      = 1'b0;
        value         = {acc_reg[6:0], head.bit_val};
        idx           = emit_reg;
        if (head.first)
        begin
            acc_next  = 8'd0;
            cnt_next  = 3'd0;
            len_next  = 32'd0;
            emit_next = 34'd0;
            done_next = 1'b0;
            value     = {7'd0, head.bit_val};
            idx       = 34'd0;
        end
        if (!done_next)
        begin
            if (head.bit_vld)
            begin
                if (cnt_next == 3'd7)
                begin
                    produced = 1'b1;
                    acc_next = 8'd0;
                    cnt_next = 3'd0;
                end
                else
                begin
                    acc_next = value;
                    cnt_next = cnt_next + 3'd1;
                end
            end
            if (produced)
            begin
                emit_next = idx + 34'd1;
                if (idx[33:2] == 32'd0)
                begin
                    len_next      = {len_next[23:0], value};
                    thr_ok_next   = {2'b00, len_next} + OK_OFFSET;
                    thr_fail_next = {2'b00, len_next} + FAIL_OFFSET;
                    if (idx[1:0] == 2'd3 && len_next == 32'd0)
                    begin
                        done_next = 1'b1;
                        res_vld   = 1'b1;
                        res       = '{payload_byte: value, outcome: OUTCOME_FAIL,
                                      message_length: 34'd0};
                    end
                end
                else if (idx >= thr_ok_reg && value == 8'd0)
                begin
                    done_next = 1'b1;
                    res_vld   = 1'b1;
                    res       = '{payload_byte: value, outcome: OUTCOME_SUCCESS,
                                  message_length: idx + 34'd1};
                end
                else if (idx >= thr_fail_reg)
                begin
                    done_next = 1'b1;
                    res_vld   = 1'b1;
                    res       = '{payload_byte: value, outcome: OUTCOME_FAIL,
                                  message_length: 34'd0};
                end
            end
            if (!res_vld && head.last)
            begin
                done_next = 1'b1;
                res_vld   = 1'b1;
                res       = '{payload_byte: produced ? value : 8'd0, outcome: OUTCOME_FAIL,
                              message_length: 34'd0};
            end
            else if (!res_vld && produced)
            begin
                res_vld = 1'b1;
                res     = '{payload_byte: value, outcome: OUTCOME_MORE,
                            message_length: 34'd0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            acc_reg      <= acc_next;
            len_reg      <= len_next;
            thr_ok_reg   <= thr_ok_next;
            thr_fail_reg <= thr_fail_next;
        end
        if (pop && res_vld)
        begin
            out_item_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= 3'd0;
            emit_reg    <= 34'd0;
            done_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cnt_reg  <= cnt_next;
                emit_reg <= emit_next;
                done_reg <= done_next;
            end
            if (!out_vld_reg || !out_stall)
            begin
                out_vld_reg <= pop && res_vld;
            end
        end
    end

endmodule

@@ rtl/core/lsbi_stego_extract_unit.sv @@
// ----------------------------------------------------------------------------
// LSB-I steganography extractor
// Recovers a length-prefixed message hidden in the low bits of pixel bytes.
// ----------------------------------------------------------------------------
// The unit accepts one pixel byte per clock cycle while in_stall is low, and
// delivers each extracted byte as one transfer, the four length bytes first.
// A result passes through the two-entry event queue between the front end
// and the back end, and then through the output register. A stall on the
// output fills the queue and then stalls the input.
// The control word is sampled when the fourth byte of an image arrives.
module lsbi_stego_extract_unit import lsbi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_item,
    input  logic       cfg_write_en,
    input  logic [3:0] cfg_write_data
);

    logic [3:0] control_word_reg;
    logic       q_full;
    logic       push;
    bit_event_t push_event;
    logic       head_vld;
    logic       pop;
    bit_event_t head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_word_reg <= 4'd0;
        end
        else if (cfg_write_en)
        begin
            control_word_reg <= cfg_write_data;
        end
    end

    lsbi_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_item      (in_item),
        .control_word (control_word_reg),
        .q_full       (q_full),
        .push         (push),
        .push_event   (push_event)
    );

    lsbi_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_event (push_event),
        .full       (q_full),
        .head_vld   (head_vld),
        .pop        (pop),
        .head       (head)
    );

    lsbi_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_vld  (head_vld),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // A success needs a nonzero length, so at least six bytes were extracted.
    a_success_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.outcome == OUTCOME_SUCCESS
        |-> out_item.message_length >= 34'd6 && out_item.payload_byte == 8'd0)
        else $error("success result with bad length or terminator");

    a_other_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.outcome != OUTCOME_SUCCESS
        |-> out_item.message_length == 34'd0)
        else $error("message length set on a result that is not a success");

    a_queue_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        q_full && out_valid && out_stall |=> in_stall)
        else $error("queue drained while the output is stalled");

endmodule
